// File: hdl/spea_pkg.sv
package spea_pkg;

    // capture ring
    localparam int RING_DEPTH_I = 5;
    localparam logic [2:0] RING_DEPTH = 3'(RING_DEPTH_I);
    localparam int N_CAPS = 5;

    // field widths
    localparam int CAP_W   = 16;
    localparam int ANG_W   = 16;
    localparam int APP_W   = 17;
    localparam int SPAN_W  = 17;
    localparam int TURN_W  = 32;
    localparam int PROD_W  = APP_W + CAP_W;
    localparam int DIV_STEPS = (PROD_W + 1) / 2;
    localparam int DIVD_W  = 2 * DIV_STEPS;
    localparam int CNT_W   = $clog2(DIV_STEPS + 1);

    localparam int IN_W  = 120;
    localparam int OUT_W = 72;

    // configuration register indexes
    localparam logic [1:0] CFG_ANGLE_PER_PULSE = 2'd0;
    localparam logic [1:0] CFG_POLE_PAIRS      = 2'd1;
    localparam logic [1:0] CFG_STOP_LIMIT      = 2'd2;

    // direction codes
    localparam logic [1:0] DIR_ZERO  = 2'b00;
    localparam logic [1:0] DIR_POS   = 2'b01;
    localparam logic [1:0] DIR_NEG2  = 2'b10;
    localparam logic [1:0] DIR_NEG   = 2'b11;

    localparam logic [ANG_W-1:0] HALF_TURN = 16'h8000;

    typedef struct packed {
        logic load;
        logic mm_step;
        logic span_step;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    // signed direction times x, modulo 2^16
    function automatic logic [ANG_W-1:0] f_dir_mul(input logic [1:0] dir,
                                                   input logic [ANG_W-1:0] x);
        logic [ANG_W-1:0] r;
        case (dir) inside
            DIR_POS:  r = x;
            DIR_NEG:  r = ANG_W'(0) - x;
            DIR_NEG2: r = ANG_W'(0) - {x[ANG_W-2:0], 1'b0};
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/spea_ctrl.sv
module spea_ctrl
    import spea_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MINMAX = 3'd1;
    localparam logic [2:0] S_SPAN   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_MINMAX;
                end
            end
            S_MINMAX: begin
                o_cmd.mm_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N_CAPS - 1)) begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                o_cmd.span_step = 1'b1;
                n_cnt           = '0;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: hdl/spea_dp.sv
module spea_dp
    import spea_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [APP_W-1:0] i_cfg_data
);

    // config
    logic [APP_W-1:0] r_app;
    logic [7:0]       r_pole_pairs;
    logic [15:0]      r_stop_limit;

    // item
    logic [1:0]       r_dir;
    logic [CAP_W-1:0] r_last;
    logic [CAP_W-1:0] r_tnow;
    logic [CAP_W-1:0] r_cap [N_CAPS];
    logic [2:0]       r_pulses;

    // block state
    logic [2:0]        r_prev_rem;
    logic [15:0]       r_idle;
    logic              r_supp;
    logic [SPAN_W-1:0] r_span;
    logic [ANG_W-1:0]  r_accum;
    logic [ANG_W-1:0]  r_prev_ang;
    logic [7:0]        r_cross;
    logic [TURN_W-1:0] r_turns;

    // work
    logic [CAP_W-1:0]  r_lo, r_hi;
    logic              r_spike;
    logic [DIVD_W-1:0] r_divd;
    logic [SPAN_W-1:0] r_rem;
    logic [ANG_W-1:0]  r_quo;

    // output
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out;

    // ---- load: pulse count and idle tracking
    logic [2:0]  w_n;
    logic [3:0]  w_pulses;
    logic [15:0] n_idle;
    logic        n_supp;

    always_comb begin
        w_n = i_s_tdata[4:2];
        if (w_n > RING_DEPTH) begin
            w_n = RING_DEPTH;
        end
        if (w_n <= r_prev_rem) begin
            w_pulses = {1'b0, r_prev_rem} - {1'b0, w_n};
        end else begin
            w_pulses = {1'b0, r_prev_rem} + {1'b0, RING_DEPTH} - {1'b0, w_n};
        end
        n_idle = r_idle;
        n_supp = r_supp;
        if (w_pulses != 4'd0) begin
            n_idle = '0;
            n_supp = 1'b0;
        end else if (r_idle != 16'hFFFF) begin
            n_idle = r_idle + 1'b1;
        end
        if (n_idle > r_stop_limit) begin
            n_supp = 1'b1;
        end
    end

    // ---- span filter
    logic [CAP_W+2:0]  w_lo8;
    logic [CAP_W+1:0]  w_lo3;
    logic [SPAN_W:0]   w_avg;
    logic [18:0]       w_pa;
    logic [PROD_W-1:0] w_prod;
    logic              w_spike;

    assign w_lo8  = {r_lo, 3'b000};
    assign w_lo3  = {2'b00, r_lo} + {1'b0, r_lo, 1'b0};
    assign w_avg  = ({1'b0, r_span} + {2'b00, r_last} + 18'd1) >> 1;
    assign w_pa   = {3'b000, r_app[ANG_W-1:0]} * {16'b0, r_pulses};
    assign w_prod = r_app * r_tnow;
    // spike of the current item, from its finished min/max
    assign w_spike = ({3'b000, r_hi} > w_lo8) && (r_lo != '0);

    // ---- divider, two quotient bits a cycle
    logic [SPAN_W:0]   w_r1, w_r2;
    logic [SPAN_W-1:0] w_m1, w_m2;
    logic              w_q1, w_q2;

    always_comb begin
        w_r1 = {r_rem, r_divd[DIVD_W-1]};
        w_q1 = (w_r1 >= {1'b0, r_span});
        w_m1 = w_q1 ? SPAN_W'(w_r1 - {1'b0, r_span}) : w_r1[SPAN_W-1:0];
        w_r2 = {w_m1, r_divd[DIVD_W-2]};
        w_q2 = (w_r2 >= {1'b0, r_span});
        w_m2 = w_q2 ? SPAN_W'(w_r2 - {1'b0, r_span}) : w_r2[SPAN_W-1:0];
    end

    // ---- finish: angle and turn counting
    logic [ANG_W-1:0] w_interp;
    logic [ANG_W-1:0] w_ang;
    logic             w_up;

    assign w_interp = (r_supp || r_span == '0) ? '0 : r_quo;
    assign w_ang    = r_accum + f_dir_mul(r_dir, w_interp);
    assign w_up     = (r_prev_ang <= HALF_TURN) && (w_ang > HALF_TURN);

    assign o_sts.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_app        <= APP_W'(65536);
            r_pole_pairs <= 8'd1;
            r_stop_limit <= 16'd1000;
            r_prev_rem   <= '0;
            r_idle       <= '0;
            r_supp       <= 1'b1;
            r_span       <= SPAN_W'(65535);
            r_accum      <= '0;
            r_prev_ang   <= '0;
            r_cross      <= '0;
            r_turns      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ANGLE_PER_PULSE: r_app        <= i_cfg_data;
                    CFG_POLE_PAIRS:      r_pole_pairs <= i_cfg_data[7:0];
                    CFG_STOP_LIMIT:      r_stop_limit <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_prev_rem <= w_n;
                r_idle     <= n_idle;
                r_supp     <= n_supp;
            end
            if (i_cmd.span_step) begin
                if (!w_spike) begin
                    if ({2'b00, r_hi} > w_lo3) begin
                        r_span <= {1'b0, r_hi};
                    end else begin
                        r_span <= w_avg[SPAN_W-1:0];
                    end
                end
                r_accum <= r_accum + f_dir_mul(r_dir, w_pa[ANG_W-1:0]);
            end
            if (i_cmd.finish) begin
                r_prev_ang <= w_ang;
                if (w_up) begin
                    if (r_cross == '0) begin
                        r_turns <= r_turns + 1'b1;
                        r_cross <= r_pole_pairs;
                    end else begin
                        r_cross <= r_cross - 1'b1;
                    end
                end
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dir    <= i_s_tdata[1:0];
            r_last   <= i_s_tdata[20:5];
            r_tnow   <= i_s_tdata[36:21];
            for (int i = 0; i < N_CAPS; i++) begin
                r_cap[i] <= i_s_tdata[37 + CAP_W*i +: CAP_W];
            end
            r_pulses <= w_pulses[2:0];
            r_lo     <= 16'hFFFF;
            r_hi     <= '0;
        end
        if (i_cmd.mm_step) begin
            if (r_cap[0] < r_lo) r_lo <= r_cap[0];
            if (r_cap[0] > r_hi) r_hi <= r_cap[0];
            for (int i = 0; i < N_CAPS - 1; i++) begin
                r_cap[i] <= r_cap[i+1];
            end
            r_cap[N_CAPS-1] <= r_cap[0];
        end
        if (i_cmd.span_step) begin
            r_spike <= w_spike;
            r_divd  <= DIVD_W'(w_prod);
            r_rem   <= '0;
            r_quo   <= '0;
        end
        if (i_cmd.div_step) begin
            r_divd <= {r_divd[DIVD_W-3:0], 2'b00};
            r_rem  <= w_m2;
            r_quo  <= {r_quo[ANG_W-3:0], w_q1, w_q2};
        end
        if (i_cmd.finish) begin
            r_out <= {2'b00, r_turns + TURN_W'(w_up && r_cross == '0), r_span,
                      r_supp, r_spike, r_pulses, w_ang};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // span never reaches zero, so the divider always has a valid divisor
    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_span != '0)
        else $error("pulse span is zero");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_span))
        else $error("divider remainder out of range");

    // a result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten");

endmodule

// File: hdl/single_pulse_encoder_angle_core.sv
// Rotor angle estimator for a single-pulse encoder. One item per control tick
// carries the direction, the capture ring's remaining count, the latest
// capture, the running timer and the five ring captures; each item yields one
// result with the interpolated 16-bit angle, the new pulse count, the spike
// and stop flags, the filtered pulse period and the turn count. The result
// sits in the output register once these steps are done: the load happens in
// the accepting cycle itself, then a serial min/max over the ring captures,
// a period filter step that also forms the interpolation product, the
// radix-4 restoring divider that forms angle_per_pulse*timer_now/period, and
// a finish step. The divider is the longest of these steps. The next item is
// accepted in the cycle after finish, so the block takes no new item before
// the last one is finished; finish waits while an earlier result still sits
// unaccepted in the output register, which delays the next acceptance.
// There is no clearing pass after reset. Configuration writes are always ready
// and should be made while idle.
module single_pulse_encoder_angle_core
    import spea_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] direction, [4:2] dma_remaining, [20:5] last_capture,
    // [36:21] timer_now, [52:37] capture_a, [68:53] capture_b,
    // [84:69] capture_c, [100:85] capture_d, [116:101] capture_e, [119:117] 0
    input  logic [IN_W-1:0]  s_axis_tdata,

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [15:0] rotor_angle, [18:16] new_pulses, [19] spike_error, [20] stopped,
    // [37:21] pulse_span, [69:38] turn_count, [71:70] 0
    output logic [OUT_W-1:0] m_axis_tdata,

    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [APP_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // config writes are always accepted; o_cfg_ready is tied high
    assign o_cfg_ready = 1'b1;

    // sequencer: load, min/max sweep, period filter, divide, finish
    spea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // all arithmetic, block state, config registers and output register
    spea_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tdata   (s_axis_tdata),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
